/* rtl/accel_step_detector_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer step detector
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_STEP_DETECTOR_ASSERT_SVH
`define ACCEL_STEP_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/asd_pkg.sv */
// ----------------------------------------------------------------------------
// asd_pkg
// Types, register indexes and reset values for the step detector.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int ASD_WINDOW = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEPS_W    = 24;
    localparam int CADENCE_W  = 16;
    localparam int DIST_W     = 40;
    localparam int TICK_W     = 32;
    localparam int MAG_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAD_NUM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 3'd5;

    localparam logic [CFG_DATA_W-1:0] RST_GRAVITY  = 16'd10035;
    localparam logic [CFG_DATA_W-1:0] RST_STEP_THR = 16'd2560;
    localparam logic [CFG_DATA_W-1:0] RST_AVG_THR  = 16'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_MIN_INT  = 16'd200;
    localparam logic [CFG_DATA_W-1:0] RST_CAD_NUM  = 16'd60000;
    localparam logic [CFG_DATA_W-1:0] RST_STRIDE   = 16'd700;

    localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } asd_in_t;

    typedef struct packed {
        logic                 step_seen;
        logic [STEPS_W-1:0]   step_total;
        logic [CADENCE_W-1:0] cadence;
        logic [DIST_W-1:0]    distance_mm;
    } asd_out_t;

endpackage

/* rtl/accel_step_detector.sv */
// A sample passes through squaring, the square root, the window push, the average
// products and the decision, plus the divider when a counted step updates the cadence.
// One sample at a time, held by the 16-step square root, the 16-step cadence
// divider and a stalled output; the input is not ready meanwhile.
// Reset (rst_n, asynchronous, active low) restores the register defaults and
// clears the window, tick, step and cadence state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// accel_step_detector
// Threshold step detector on accelerometer samples: magnitude by square root,
// windowed average test, debounce interval, saturating count, cadence, distance.
// ----------------------------------------------------------------------------
module accel_step_detector import asd_pkg::*;
#(
    parameter int WINDOW = ASD_WINDOW
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  asd_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output asd_out_t              out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = MAG_W + FILL_W;

    // Sequencer: square and accumulate, root, window push, average products,
    // decision, optional cadence division, then hand the result to the output.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_AVG_G,
        ST_AVG_T,
        ST_DECIDE,
        ST_DIV_WAIT,
        ST_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [CFG_DATA_W-1:0] gravity_reg;
    logic [CFG_DATA_W-1:0] step_thr_reg;
    logic [CFG_DATA_W-1:0] avg_thr_reg;
    logic [CFG_DATA_W-1:0] min_int_reg;
    logic [CFG_DATA_W-1:0] cad_num_reg;
    logic [CFG_DATA_W-1:0] stride_reg;

    // Control state
    logic [1:0]           sq_cnt_reg;
    logic                 out_valid_reg;
    logic                 was_above_reg;
    logic [TICK_W-1:0]    tick_reg;
    logic [TICK_W-1:0]    last_step_reg;
    logic [STEPS_W-1:0]   steps_reg;
    logic [CADENCE_W-1:0] cadence_reg;

    // Datapath registers
    logic signed [15:0]   ax_reg;
    logic signed [15:0]   ay_reg;
    logic signed [15:0]   az_reg;
    logic signed [33:0]   prod_reg;
    logic [31:0]          acc_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [SUM_W-1:0]     gn_reg;
    logic                 seen_reg;
    asd_out_t             out_reg;

    // Shared multiplier
    logic signed [16:0]   mul_a;
    logic signed [16:0]   mul_b;
    logic signed [15:0]   sq_op;
    logic signed [33:0]   mul_p;

    // Sub-unit handshakes
    logic                 root_start;
    logic                 root_done;
    logic [MAG_W-1:0]     root_val;
    logic                 div_start;
    logic                 div_done;
    logic [CADENCE_W-1:0] div_q;
    logic                 ring_push;
    logic [FILL_W-1:0]    ring_fill;
    logic [SUM_W-1:0]     ring_sum;

    // Decision logic
    logic [MAG_W-1:0]     dev_mag;
    logic                 above;
    logic [SUM_W-1:0]     thr_n;
    logic [SUM_W-1:0]     adev;
    logic                 avg_ok;
    logic [TICK_W-1:0]    elapsed;
    logic                 interval_ok;
    logic                 step_hit;
    logic                 fin_go;
    logic [DIST_W-1:0]    distance;

    // ------------------------------------------------------------------
    // Configuration: always ready, unknown indexes drop the write
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg  <= RST_GRAVITY;
            step_thr_reg <= RST_STEP_THR;
            avg_thr_reg  <= RST_AVG_THR;
            min_int_reg  <= RST_MIN_INT;
            cad_num_reg  <= RST_CAD_NUM;
            stride_reg   <= RST_STRIDE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRAVITY:  gravity_reg  <= cfg_data;
                CFG_STEP_THR: step_thr_reg <= cfg_data;
                CFG_AVG_THR:  avg_thr_reg  <= cfg_data;
                CFG_MIN_INT:  min_int_reg  <= cfg_data;
                CFG_CAD_NUM:  cad_num_reg  <= cfg_data;
                CFG_STRIDE:   stride_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: squares of the axes, then gravity*n and threshold*n
    // ------------------------------------------------------------------
    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sq_op = ax_reg;
            2'd1:    sq_op = ay_reg;
            default: sq_op = az_reg;
        endcase
    end

    always_comb
    begin
        mul_a = {sq_op[15], sq_op};
        mul_b = {sq_op[15], sq_op};
        case (state_reg)
            ST_AVG_G:
            begin
                mul_a = {1'b0, gravity_reg};
                mul_b = {{(17 - FILL_W){1'b0}}, ring_fill};
            end
            ST_AVG_T:
            begin
                mul_a = {1'b0, avg_thr_reg};
                mul_b = {{(17 - FILL_W){1'b0}}, ring_fill};
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Iterative units and the magnitude window
    // ------------------------------------------------------------------
    assign root_start = state_reg == ST_ROOT_GO;
    assign ring_push  = (state_reg == ST_ROOT_WAIT) && root_done;

    asd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (acc_reg),
        .done     (root_done),
        .root     (root_val)
    );

    asd_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ring_push),
        .mag   (root_val),
        .fill  (ring_fill),
        .sum   (ring_sum)
    );

    asd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cad_num_reg),
        .divisor  (elapsed),
        .done     (div_done),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // Step decision, evaluated in the decide state
    // ------------------------------------------------------------------
    assign dev_mag = (mag_reg >= gravity_reg) ? mag_reg - gravity_reg
                                              : gravity_reg - mag_reg;
    assign above   = dev_mag > step_thr_reg;

    // Compare |sum - g*n| against thr*n exactly; thr*n sits in the product reg.
    assign thr_n  = prod_reg[SUM_W-1:0];
    assign adev   = (ring_sum >= gn_reg) ? ring_sum - gn_reg : gn_reg - ring_sum;
    assign avg_ok = adev > thr_n;

    // Elapsed ticks wrap modulo 2^32.
    assign elapsed     = tick_reg - last_step_reg;
    assign interval_ok = elapsed >= {{(TICK_W - CFG_DATA_W){1'b0}}, min_int_reg};
    assign step_hit    = above && !was_above_reg && avg_ok && interval_ok;

    // A zero interval counts the step but leaves the cadence alone.
    assign div_start = (state_reg == ST_DECIDE) && step_hit && (elapsed != '0);

    assign fin_go   = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign distance = {{(DIST_W - STEPS_W){1'b0}}, steps_reg}
                    * {{(DIST_W - CFG_DATA_W){1'b0}}, stride_reg};

    // ------------------------------------------------------------------
    // Sequencer and control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            was_above_reg <= 1'b0;
            tick_reg      <= '0;
            last_step_reg <= '0;
            steps_reg     <= '0;
            cadence_reg   <= '0;
        end
        else
        begin
            // Drop valid once the result is taken, unless a new one follows.
            if (out_valid_reg && out_ready && !fin_go)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    sq_cnt_reg <= sq_cnt_reg + 2'd1;
                    if (sq_cnt_reg == 2'd3)
                    begin
                        state_reg <= ST_ROOT_GO;
                    end
                end
                ST_ROOT_GO:
                begin
                    state_reg <= ST_ROOT_WAIT;
                end
                ST_ROOT_WAIT:
                begin
                    if (root_done)
                    begin
                        state_reg <= ST_AVG_G;
                    end
                end
                ST_AVG_G:
                begin
                    state_reg <= ST_AVG_T;
                end
                ST_AVG_T:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    was_above_reg <= above;
                    tick_reg      <= tick_reg + 1'b1;
                    if (step_hit)
                    begin
                        if (steps_reg != STEPS_MAX)
                        begin
                            steps_reg <= steps_reg + 1'b1;
                        end
                        last_step_reg <= tick_reg;
                    end
                    state_reg <= div_start ? ST_DIV_WAIT : ST_FIN;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        cadence_reg <= div_q;
                        state_reg   <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    // Hold here while the previous result is still unclaimed.
                    if (fin_go)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;

        if (in_valid && in_ready)
        begin
            ax_reg <= in_data.accel_x;
            ay_reg <= in_data.accel_y;
            az_reg <= in_data.accel_z;
        end

        // Accumulate the squares one product behind the multiplier.
        if (state_reg == ST_SQUARE)
        begin
            acc_reg <= (sq_cnt_reg == 2'd0) ? '0 : acc_reg + prod_reg[31:0];
        end

        if (ring_push)
        begin
            mag_reg <= root_val;
        end

        if (state_reg == ST_AVG_T)
        begin
            gn_reg <= prod_reg[SUM_W-1:0];
        end

        if (state_reg == ST_DECIDE)
        begin
            seen_reg <= step_hit;
        end

        if (fin_go)
        begin
            out_reg.step_seen   <= seen_reg;
            out_reg.step_total  <= steps_reg;
            out_reg.cadence     <= cadence_reg;
            out_reg.distance_mm <= distance;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "accel_step_detector_assert.svh"

    `ASD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input ready right after a transaction")
    `ASD_ASSERT_SAME(a_root_done_expected, root_done, state_reg == ST_ROOT_WAIT, "square root finished outside its wait state")
    `ASD_ASSERT_SAME(a_div_done_expected, div_done, state_reg == ST_DIV_WAIT, "divider finished outside its wait state")
    `ASD_ASSERT_SAME(a_seen_counts, out_valid && out_data.step_seen, out_data.step_total != '0, "step reported with an empty step count")

endmodule

/* rtl/asd_isqrt.sv */
// ----------------------------------------------------------------------------
// asd_isqrt
// Digit-by-digit floor square root of a 32-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module asd_isqrt import asd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      radicand,
    output logic             done,
    output logic [MAG_W-1:0] root
);

    logic [31:0]      rad_reg;
    logic [16:0]      rem_reg;
    logic [MAG_W-1:0] root_reg;
    logic [3:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [18:0] rem_sh;
    logic [18:0] trial;
    logic [18:0] diff;
    logic        fits;

    assign rem_sh = {rem_reg, rad_reg[31:30]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == 4'd15);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[29:0], 2'b00};
            rem_reg  <= fits ? diff[16:0] : rem_sh[16:0];
            root_reg <= {root_reg[MAG_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/asd_div.sv */
// ----------------------------------------------------------------------------
// asd_div
// Restoring divider: 16-bit dividend by 32-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module asd_div import asd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [CFG_DATA_W-1:0] dividend,
    input  logic [TICK_W-1:0]     divisor,
    output logic                  done,
    output logic [CADENCE_W-1:0]  quotient
);

    logic [CADENCE_W-1:0] q_reg;
    logic [15:0]          rem_reg;
    logic [TICK_W-1:0]    dvs_reg;
    logic [3:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [16:0] rem_sh;
    logic        ge;
    logic [16:0] diff;

    // Partial remainder never exceeds the dividend prefix, so 17 bits suffice.
    assign rem_sh = {rem_reg, q_reg[CADENCE_W-1]};
    assign ge     = {16'b0, rem_sh} >= {1'b0, dvs_reg};
    assign diff   = rem_sh - dvs_reg[16:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == 4'd15);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[15:0] : rem_sh[15:0];
            q_reg   <= {q_reg[CADENCE_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/asd_ring.sv */
// ----------------------------------------------------------------------------
// asd_ring
// Magnitude window: ring memory with head, fill count and running sum.
// ----------------------------------------------------------------------------
module asd_ring import asd_pkg::*;
#(
    parameter int WINDOW = ASD_WINDOW
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic [MAG_W-1:0]                  mag,
    output logic [$clog2(WINDOW+1)-1:0]       fill,
    output logic [MAG_W+$clog2(WINDOW+1)-1:0] sum
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int HEAD_W = $clog2(WINDOW);
    localparam int SUM_W  = MAG_W + FILL_W;

    logic [MAG_W-1:0]  mem [WINDOW];
    logic [MAG_W-1:0]  rd_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic              full;
    logic [SUM_W-1:0]  drop_val;

    assign full     = fill_reg == FILL_W'(WINDOW);
    // Drop the oldest entry only once the window is full.
    assign drop_val = full ? {{FILL_W{1'b0}}, rd_reg} : '0;

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[head_reg];
        if (push)
        begin
            mem[head_reg] <= mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (push)
        begin
            head_reg <= (head_reg == HEAD_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
            if (!full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            sum_reg <= sum_reg - drop_val + {{FILL_W{1'b0}}, mag};
        end
    end

    assign fill = fill_reg;
    assign sum  = sum_reg;

endmodule

/* dv/step_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_result_checker
// Watches the sample, result and register channels of the step detector,
// predicts every result from its own copy of the detector state and compares
// each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module step_result_checker import asd_pkg::*;
#(
    parameter int WINDOW = ASD_WINDOW
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  asd_in_t               in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  asd_out_t              out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    // keep the log readable when the block is badly broken
    localparam int PRINT_CAP = 40;

    logic [CFG_DATA_W-1:0] reg_gravity;
    logic [CFG_DATA_W-1:0] reg_step_thr;
    logic [CFG_DATA_W-1:0] reg_avg_thr;
    logic [CFG_DATA_W-1:0] reg_min_gap;
    logic [CFG_DATA_W-1:0] reg_cad_num;
    logic [CFG_DATA_W-1:0] reg_stride;

    logic [MAG_W-1:0]     win_mag [WINDOW];
    int                   win_head;
    int                   win_count;
    longint               win_total;
    logic                 prev_over;
    logic [TICK_W-1:0]    last_step_tick;
    logic [TICK_W-1:0]    sample_tick;
    logic [STEPS_W-1:0]   step_count;
    logic [CADENCE_W-1:0] cadence_now;

    asd_out_t due_results [$];
    int       results_seen;

    // Largest r with r*r <= v, settled one bit at a time from the top.
    function automatic logic [MAG_W-1:0] floor_root(input logic [63:0] v);
        logic [MAG_W-1:0] r;
        logic [MAG_W-1:0] t;
        r = '0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            t = r | (MAG_W'(1) << b);
            if (64'(t) * 64'(t) <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic asd_out_t predict_step_result(input asd_in_t s);
        asd_out_t          r;
        longint            ax;
        longint            ay;
        longint            az;
        longint            dev;
        longint            avg_dev;
        logic [MAG_W-1:0]  mag;
        logic              over;
        logic              avg_ok;
        logic [TICK_W-1:0] gap;
        ax  = longint'($signed(s.accel_x));
        ay  = longint'($signed(s.accel_y));
        az  = longint'($signed(s.accel_z));
        mag = floor_root(64'(ax * ax + ay * ay + az * az));

        // push into the window, dropping the oldest entry once full
        if (win_count == WINDOW)
            win_total -= longint'(win_mag[win_head]);
        else
            win_count++;
        win_mag[win_head] = mag;
        win_total += longint'(mag);
        win_head = (win_head == WINDOW - 1) ? 0 : win_head + 1;

        dev = longint'(mag) - longint'(reg_gravity);
        if (dev < 0)
            dev = -dev;
        over = dev > longint'(reg_step_thr);

        // window mean against gravity, scaled by the fill instead of divided
        avg_dev = win_total - longint'(reg_gravity) * win_count;
        if (avg_dev < 0)
            avg_dev = -avg_dev;
        avg_ok = avg_dev > longint'(reg_avg_thr) * win_count;

        r.step_seen = 1'b0;
        if (over && !prev_over && avg_ok) begin
            gap = sample_tick - last_step_tick;
            if (gap >= TICK_W'(reg_min_gap)) begin
                r.step_seen = 1'b1;
                if (step_count != STEPS_MAX)
                    step_count++;
                if (gap != '0)
                    cadence_now = CADENCE_W'(TICK_W'(reg_cad_num) / gap);
                last_step_tick = sample_tick;
            end
        end
        prev_over = over;
        sample_tick++;

        r.step_total  = step_count;
        r.cadence     = cadence_now;
        r.distance_mm = DIST_W'(step_count) * DIST_W'(reg_stride);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t: MISMATCH %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n) begin
        asd_out_t want;
        if (!rst_n) begin
            reg_gravity    = RST_GRAVITY;
            reg_step_thr   = RST_STEP_THR;
            reg_avg_thr    = RST_AVG_THR;
            reg_min_gap    = RST_MIN_INT;
            reg_cad_num    = RST_CAD_NUM;
            reg_stride     = RST_STRIDE;
            for (int i = 0; i < WINDOW; i++)
                win_mag[i] = '0;
            win_head       = 0;
            win_count      = 0;
            win_total      = 0;
            prev_over      = 1'b0;
            last_step_tick = '0;
            sample_tick    = '0;
            step_count     = '0;
            cadence_now    = '0;
            results_seen   = 0;
            fail_count     = 0;
            due_results.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GRAVITY:  reg_gravity  = cfg_data;
                    CFG_STEP_THR: reg_step_thr = cfg_data;
                    CFG_AVG_THR:  reg_avg_thr  = cfg_data;
                    CFG_MIN_INT:  reg_min_gap  = cfg_data;
                    CFG_CAD_NUM:  reg_cad_num  = cfg_data;
                    CFG_STRIDE:   reg_stride   = cfg_data;
                    default:      ;
                endcase
            end
            if (in_valid && in_ready)
                due_results.push_back(predict_step_result(in_data));
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no sample waiting",
                                              results_seen));
                end else begin
                    want = due_results.pop_front();
                    check_field("step_seen", 64'(out_data.step_seen), 64'(want.step_seen));
                    check_field("step_total", 64'(out_data.step_total),
                                64'(want.step_total));
                    check_field("cadence", 64'(out_data.cadence), 64'(want.cadence));
                    check_field("distance_mm", 64'(out_data.distance_mm),
                                64'(want.distance_mm));
                end
                results_seen++;
            end
            pending <= due_results.size();
        end
    end

endmodule

/* dv/tb_accel_step_detector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_step_detector
// Drives accelerometer samples and register writes into the step detector
// under varied flow control and hands the result channel to a predicting
// checker; reports the verdict once every predicted result has arrived.
// ----------------------------------------------------------------------------
module tb_accel_step_detector;
    import asd_pkg::*;

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } flow_mode_t;

    // indexes past the register map; writes to them must leave no trace
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int     HALF_PERIOD     = 5;
    localparam int     RESET_CYCLES    = 9;
    localparam int     PHASES          = 8;
    localparam int     PHASE_SAMPLES   = 115;
    localparam int     HOLD_OFF_CYCLES = 600;
    // the longest latency comes with a cadence division
    localparam int     TAIL_CYCLES     = 60;
    // largest magnitude that three 16-bit axes can produce
    localparam int     MAG_CEIL        = 56755;
    localparam longint RUN_LIMIT_NS    = 5_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    asd_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    asd_out_t              out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;

    // flow control knobs, percentages of cycles spent idle or stalled
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holds_asked   = 0;

    // register values as last written, used only to shape the stimulus
    int cur_gravity  = RST_GRAVITY;
    int cur_step_thr = RST_STEP_THR;
    int cur_avg_thr  = RST_AVG_THR;

    accel_step_detector dut (.*);

    step_result_checker result_check (.*);

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic asd_in_t xyz(input int x, input int y, input int z);
        asd_in_t s;
        s.accel_x = 16'(x);
        s.accel_y = 16'(y);
        s.accel_z = 16'(z);
        return s;
    endfunction

    function automatic int signed_axis(input int mag);
        return ($urandom_range(1) != 0) ? -mag : mag;
    endfunction

    // Build a sample whose magnitude lands near the requested level: one
    // dominant axis with light noise on the others, or all three axes shared
    // once a single axis can no longer carry it.
    function automatic asd_in_t shaped_sample(input int level);
        int share;
        asd_in_t s;
        if (level < 0)
            level = 0;
        if (level > MAG_CEIL)
            level = MAG_CEIL;
        if (level <= 32767) begin
            s = xyz(signed_axis($urandom_range(0, 100)), signed_axis($urandom_range(0, 100)),
                    signed_axis($urandom_range(0, 100)));
            case ($urandom_range(2))
                0:       s.accel_x = 16'(signed_axis(level));
                1:       s.accel_y = 16'(signed_axis(level));
                default: s.accel_z = 16'(signed_axis(level));
            endcase
        end else begin
            share = (level * 577) / 1000;
            s = xyz(signed_axis(share), signed_axis(share), signed_axis(share));
        end
        return s;
    endfunction

    // Offer one sample and return at the edge that accepts it. Valid is left
    // high so that a following sample can go out back to back; drop it only
    // when an idle gap is drawn, never in the step that raises it again.
    task automatic send_sample(input asd_in_t s);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold a write until its transaction completes. Valid stays high for a
    // following write; the caller drops it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_GRAVITY:  cur_gravity  = val & 16'hFFFF;
            CFG_STEP_THR: cur_step_thr = val & 16'hFFFF;
            CFG_AVG_THR:  cur_avg_thr  = val & 16'hFFFF;
            default:      ;
        endcase
    endtask

    // Stop offering and wait until every predicted result has come back.
    // Wait for a clock edge first so the checker's count reflects the last sample.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request so that
    // the detector backs up and refuses samples while the sender keeps going
    // ------------------------------------------------------------------------
    initial begin : sink
        int served;
        served = 0;
        forever begin
            @(posedge clk);
            if (served < holds_asked) begin
                served++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        flow_mode_t flow;
        int         bias;
        int         spike_dev;
        int         period;
        int         laps;
        int         level;
        int         sent;

        rst_n = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, default thresholds with no debounce: the very first
        // sample is a step with zero elapsed ticks, so cadence must hold.
        write_reg(CFG_MIN_INT, 0);
        cfg_valid <= 1'b0;
        send_sample(xyz(32767, 0, 0));
        send_sample(xyz(0, 0, 10035));
        send_sample(xyz(-32768, -32768, -32768));
        send_sample(xyz(0, 0, 0));
        send_sample(xyz(0, 10035, 0));
        send_sample(xyz(0, 0, -32768));
        send_sample(xyz(10035, 0, 0));
        send_sample(xyz(32767, 32767, 32767));
        send_sample(xyz(-1, -1, -1));
        send_sample(xyz(-32768, 0, 0));
        send_sample(xyz(10035, 0, 0));
        wait_drained();

        // Zero numerator, widest stride, gravity at the top, thresholds at
        // zero; the spare indexes must not disturb anything.
        write_reg(CFG_CAD_NUM, 0);
        write_reg(CFG_STRIDE, 65535);
        write_reg(CFG_GRAVITY, 65535);
        write_reg(CFG_STEP_THR, 0);
        write_reg(CFG_AVG_THR, 0);
        write_reg(CFG_SPARE_LO, 16'h1234);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_sample(xyz(32767, 32767, 32767));
        send_sample(xyz(0, 0, 0));
        send_sample(xyz(1, 1, 1));
        send_sample(xyz(-32768, -32768, -32768));
        wait_drained();

        // Opposite extremes: nothing can clear a full-scale threshold.
        write_reg(CFG_GRAVITY, 0);
        write_reg(CFG_STEP_THR, 65535);
        write_reg(CFG_AVG_THR, 65535);
        write_reg(CFG_MIN_INT, 65535);
        write_reg(CFG_CAD_NUM, 65535);
        write_reg(CFG_STRIDE, 0);
        cfg_valid <= 1'b0;
        send_sample(xyz(-32768, -32768, -32768));
        send_sample(xyz(32767, -32768, 0));
        send_sample(xyz(0, 0, 0));

        // Random phases: fresh registers each time, then mostly walking
        // patterns (rest level offset from gravity with a periodic spike)
        // and some raw noise across the whole input range.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_reg(CFG_GRAVITY, ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                             : $urandom_range(8000, 12000));
            write_reg(CFG_STEP_THR, $urandom_range(300, 4000));
            write_reg(CFG_AVG_THR, $urandom_range(0, 1500));
            write_reg(CFG_MIN_INT, ($urandom_range(4) == 0) ? $urandom_range(0, 400)
                                                            : $urandom_range(0, 24));
            write_reg(CFG_CAD_NUM, $urandom_range(1, 65535));
            write_reg(CFG_STRIDE, $urandom_range(0, 65535));
            if ($urandom_range(2) == 0)
                write_reg(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          $urandom_range(0, 65535));
            cfg_valid <= 1'b0;

            flow = flow_mode_t'(ph % 4);
            case (flow)
                FLOW_FREE:        begin send_idle_pct = 0;  stall_pct = 0;  end
                FLOW_SENDER_IDLE: begin send_idle_pct = 77; stall_pct = 0;  end
                FLOW_SINK_STALL:  begin send_idle_pct = 0;  stall_pct = 77; end
                default:          begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            // back the block up once while samples keep arriving
            if (ph == 0)
                holds_asked++;

            sent = 0;
            while (sent < PHASE_SAMPLES) begin
                if ($urandom_range(99) < 75) begin
                    period = $urandom_range(3, 12);
                    laps   = $urandom_range(2, 6);
                    bias   = signed_axis($urandom_range(0, cur_avg_thr + 800));
                    for (int l = 0; l < laps; l++) begin
                        for (int k = 0; k < period; k++) begin
                            if (k == 0) begin
                                spike_dev = cur_step_thr + $urandom_range(1, 4000);
                                level = (cur_gravity >= spike_dev && $urandom_range(1) != 0)
                                        ? cur_gravity - spike_dev
                                        : cur_gravity + spike_dev;
                            end else begin
                                level = cur_gravity + bias + $urandom_range(0, 400) - 200;
                            end
                            send_sample(shaped_sample(level));
                            sent++;
                        end
                    end
                end else begin
                    send_sample(xyz($urandom_range(0, 65535), $urandom_range(0, 65535),
                                    $urandom_range(0, 65535)));
                    sent++;
                end
            end
        end

        // Drain, allow for any stray result, then give the verdict.
        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hang anywhere above.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/asd_pkg.sv
rtl/asd_isqrt.sv
rtl/asd_div.sv
rtl/asd_ring.sv
rtl/accel_step_detector.sv
dv/step_result_checker.sv
dv/tb_accel_step_detector.sv
